>>> hw/rtl/ihdp_pkg.sv
// Shared types and constants for the image header dimension parser.
// No dependencies.
package ihdp_pkg;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_JPEG    = 2'd1,
    KIND_BMP     = 2'd2,
    KIND_PNG     = 2'd3
  } kind_t;

  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned MOFF_W       = 4;

  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_D8  = 8'hD8;
  localparam logic [7:0] BYTE_C0  = 8'hC0;
  localparam logic [7:0] BYTE_42  = 8'h42;
  localparam logic [7:0] BYTE_4D  = 8'h4D;
  localparam logic [7:0] BYTE_89  = 8'h89;
  localparam logic [7:0] BYTE_50  = 8'h50;
  localparam logic [7:0] BYTE_4E  = 8'h4E;
  localparam logic [7:0] BYTE_47  = 8'h47;
  localparam logic [7:0] BYTE_0D  = 8'h0D;
  localparam logic [7:0] BYTE_0A  = 8'h0A;
  localparam logic [7:0] BYTE_1A  = 8'h1A;

  // byte offsets of the dimension words
  localparam logic [POS_W-1:0] BMP_W_POS = 5'd18;
  localparam logic [POS_W-1:0] BMP_H_POS = 5'd22;
  localparam logic [POS_W-1:0] BMP_END   = 5'd25;
  localparam logic [POS_W-1:0] PNG_W_POS = 5'd16;
  localparam logic [POS_W-1:0] PNG_H_POS = 5'd20;
  localparam logic [POS_W-1:0] PNG_END   = 5'd23;
  localparam logic [POS_W-1:0] CLASS_POS = 5'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] POS_MAX   = 5'd31;
  localparam logic [MOFF_W-1:0] MOFF_MAX = 4'd15;

  // enable bits of format_enable
  localparam int unsigned EN_JPEG = 0;
  localparam int unsigned EN_BMP  = 1;
  localparam int unsigned EN_PNG  = 2;

  // h0..h6 are the stored header bytes, h7 is the byte arriving now
  function automatic kind_t classify(input logic [2:0] en,
                                     input logic [7:0] h0, input logic [7:0] h1,
                                     input logic [7:0] h2, input logic [7:0] h3,
                                     input logic [7:0] h4, input logic [7:0] h5,
                                     input logic [7:0] h6, input logic [7:0] h7);
    kind_t k;
    k = KIND_UNKNOWN;
    if (en[EN_JPEG] && h0 == BYTE_FF && h1 == BYTE_D8 && h2 == BYTE_FF) begin
      k = KIND_JPEG;
    end else if (en[EN_BMP] && h0 == BYTE_42 && h1 == BYTE_4D) begin
      k = KIND_BMP;
    end else if (en[EN_PNG] && h0 == BYTE_89 && h1 == BYTE_50 && h2 == BYTE_4E &&
                 h3 == BYTE_47 && h4 == BYTE_0D && h5 == BYTE_0A &&
                 h6 == BYTE_1A && h7 == BYTE_0A) begin
      k = KIND_PNG;
    end
    return k;
  endfunction

endpackage

>>> hw/rtl/image_header_dimension_parser_top.sv
// Image header dimension parser: classifies an image file and extracts its size.
// Depends on ihdp_pkg.
//
// Takes one file byte per beat and sustains one byte per clock while the result stream
// is not back-pressured. Each byte sits in an input register, and the per-byte update
// (header compare, marker scan, dimension byte insertion) runs between that register
// and the result register. At most one result per file: when the dimensions are
// complete (BMP offset 25, PNG offset 23, JPEG seven bytes after the C0 of FF C0) or
// at the last byte. found is 0 for unknown or disabled kinds, truncated files or zero
// dimensions, and width and height then read 0. Bytes after a result are dropped
// until a beat with first_byte set. format_enable must be written only while the
// block is idle; the block itself does not enforce this.
module image_header_dimension_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] first_byte
  input  logic        in_tlast,   // last_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] pixel_width, [63:32] pixel_height
  output logic [2:0]  out_tuser,  // [1:0] image_kind, [2] found
  // configuration
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [7:0]  cfg_tdata   // [2:0] format_enable
);

  localparam int unsigned HDR_REGS = ihdp_pkg::HEADER_BYTES - 1;
  localparam int unsigned POS_W    = ihdp_pkg::POS_W;
  localparam int unsigned MOFF_W   = ihdp_pkg::MOFF_W;

  // configuration
  logic [2:0] fmt_en_r;

  // input stage
  logic       in_v_r;
  logic [7:0] byte_r;
  logic       first_r;
  logic       last_r;

  // per-file parser state
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [7:0]        hdr_r [HDR_REGS];
  ihdp_pkg::kind_t   kind_r, kind_nxt;
  logic              pff_r, pff_nxt;
  logic [MOFF_W-1:0] moff_r, moff_nxt;
  logic [31:0]       wacc_r, wacc_nxt;
  logic [31:0]       hacc_r, hacc_nxt;
  logic              given_r, given_nxt;

  // result stage
  logic              out_v_r;
  ihdp_pkg::kind_t   okind_r;
  logic [31:0]       owidth_r;
  logic [31:0]       oheight_r;
  logic              ofound_r;

  logic advance;
  logic fire;
  logic emit;
  logic found_c;

  // working copies after an optional restart
  logic [POS_W-1:0]  pos_c;
  ihdp_pkg::kind_t   kind_c;
  logic              pff_c;
  logic [MOFF_W-1:0] moff_c;
  logic              given_c;
  logic              complete;
  logic [POS_W-1:0]  lane_w;
  logic [POS_W-1:0]  lane_h;

  assign advance   = !out_v_r || out_tready;
  assign fire      = in_v_r && advance;
  assign in_tready = !in_v_r || advance;
  assign cfg_tready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_en_r <= 3'd7;
    end else if (cfg_tvalid) begin
      fmt_en_r <= cfg_tdata[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r  <= in_tdata;
      first_r <= in_tuser;
      last_r  <= in_tlast;
    end
  end

  always_comb begin
    pos_c   = first_r ? '0 : pos_r;
    kind_c  = first_r ? ihdp_pkg::KIND_UNKNOWN : kind_r;
    pff_c   = first_r ? 1'b0 : pff_r;
    moff_c  = first_r ? '0 : moff_r;
    given_c = first_r ? 1'b0 : given_r;

    pos_nxt   = pos_c;
    kind_nxt  = kind_c;
    pff_nxt   = pff_c;
    moff_nxt  = moff_c;
    wacc_nxt  = first_r ? '0 : wacc_r;
    hacc_nxt  = first_r ? '0 : hacc_r;
    given_nxt = given_c;
    complete  = 1'b0;
    emit      = 1'b0;
    found_c   = 1'b0;
    lane_w    = pos_c - ihdp_pkg::BMP_W_POS;
    lane_h    = pos_c - ihdp_pkg::BMP_H_POS;

    if (!given_c) begin
      // JPEG marker scan runs through the header and on for JPEG files
      if (pos_c < POS_W'(ihdp_pkg::HEADER_BYTES) || kind_c == ihdp_pkg::KIND_JPEG) begin
        if (moff_c == '0) begin
          if (pff_c && byte_r == ihdp_pkg::BYTE_C0) begin
            moff_nxt = MOFF_W'(1);
          end
          pff_nxt = (byte_r == ihdp_pkg::BYTE_FF);
        end else begin
          if (moff_c < ihdp_pkg::MOFF_MAX) begin
            moff_nxt = moff_c + MOFF_W'(1);
          end
          if (moff_nxt == MOFF_W'(5) || moff_nxt == MOFF_W'(6)) begin
            hacc_nxt = {16'h0000, hacc_nxt[7:0], byte_r};
          end else if (moff_nxt == MOFF_W'(7) || moff_nxt == MOFF_W'(8)) begin
            wacc_nxt = {16'h0000, wacc_nxt[7:0], byte_r};
          end
          if (moff_nxt == MOFF_W'(8) && kind_c == ihdp_pkg::KIND_JPEG) begin
            complete = 1'b1;
          end
        end
      end

      if (pos_c == ihdp_pkg::CLASS_POS) begin
        kind_nxt = ihdp_pkg::classify(fmt_en_r, hdr_r[0], hdr_r[1], hdr_r[2], hdr_r[3],
                                      hdr_r[4], hdr_r[5], hdr_r[6], byte_r);
        if (kind_nxt != ihdp_pkg::KIND_JPEG) begin
          wacc_nxt = '0;
          hacc_nxt = '0;
        end
      end

      case (kind_nxt)
        ihdp_pkg::KIND_BMP: begin
          // little-endian: byte lane chosen by offset within the word
          if (pos_c >= ihdp_pkg::BMP_W_POS && pos_c < ihdp_pkg::BMP_H_POS) begin
            for (int i = 0; i < 4; i++) begin
              if (lane_w[1:0] == 2'(i)) begin
                wacc_nxt[i*8 +: 8] = wacc_nxt[i*8 +: 8] | byte_r;
              end
            end
          end else if (pos_c >= ihdp_pkg::BMP_H_POS && pos_c <= ihdp_pkg::BMP_END) begin
            for (int i = 0; i < 4; i++) begin
              if (lane_h[1:0] == 2'(i)) begin
                hacc_nxt[i*8 +: 8] = hacc_nxt[i*8 +: 8] | byte_r;
              end
            end
          end
          if (pos_c == ihdp_pkg::BMP_END) begin
            complete = 1'b1;
          end
        end
        ihdp_pkg::KIND_PNG: begin
          if (pos_c >= ihdp_pkg::PNG_W_POS && pos_c < ihdp_pkg::PNG_H_POS) begin
            wacc_nxt = {wacc_nxt[23:0], byte_r};
          end else if (pos_c >= ihdp_pkg::PNG_H_POS && pos_c <= ihdp_pkg::PNG_END) begin
            hacc_nxt = {hacc_nxt[23:0], byte_r};
          end
          if (pos_c == ihdp_pkg::PNG_END) begin
            complete = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (pos_c < ihdp_pkg::POS_MAX) begin
        pos_nxt = pos_c + POS_W'(1);
      end

      emit    = complete || last_r;
      found_c = complete && kind_nxt != ihdp_pkg::KIND_UNKNOWN &&
                wacc_nxt != '0 && hacc_nxt != '0;
      if (emit) begin
        given_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      kind_r  <= ihdp_pkg::KIND_UNKNOWN;
      pff_r   <= 1'b0;
      moff_r  <= '0;
      wacc_r  <= '0;
      hacc_r  <= '0;
      given_r <= 1'b0;
    end else if (fire) begin
      pos_r   <= pos_nxt;
      kind_r  <= kind_nxt;
      pff_r   <= pff_nxt;
      moff_r  <= moff_nxt;
      wacc_r  <= wacc_nxt;
      hacc_r  <= hacc_nxt;
      given_r <= given_nxt;
    end
  end

  // header bytes 0..6; byte 7 is classified on the fly
  always_ff @(posedge clk) begin
    if (fire && !given_c) begin
      for (int i = 0; i < HDR_REGS; i++) begin
        if (pos_c == POS_W'(i)) begin
          hdr_r[i] <= byte_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      okind_r   <= kind_nxt;
      owidth_r  <= found_c ? wacc_nxt : '0;
      oheight_r <= found_c ? hacc_nxt : '0;
      ofound_r  <= found_c;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {oheight_r, owidth_r};
  assign out_tuser  = {ofound_r, okind_r};

endmodule

>>> tb/sv/dimension_checker.sv
`timescale 1ns / 100ps
// Checker for image_header_dimension_parser_top: watches the byte, result and
// configuration channels, predicts each result and compares it. Depends on ihdp_pkg.
module dimension_checker
  import ihdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        cfg_tvalid,
  input  logic        cfg_tready,
  input  logic [7:0]  cfg_tdata,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    kind_t       kind;
    logic [31:0] width;
    logic [31:0] height;
    logic        found;
  } dims_t;

  dims_t       expected_dims[$];

  // predicted parser state
  logic [2:0]  fmt_en;
  logic [4:0]  pos_q;
  logic [7:0]  hdr[HEADER_BYTES];
  kind_t       kind_q;
  logic        prev_ff;
  logic [3:0]  moff;
  logic [31:0] wacc;
  logic [31:0] hacc;
  logic        done_q;

  task automatic clear_file();
    pos_q   = '0;
    kind_q  = KIND_UNKNOWN;
    prev_ff = 1'b0;
    moff    = '0;
    wacc    = '0;
    hacc    = '0;
    done_q  = 1'b0;
    for (int i = 0; i < HEADER_BYTES; i++) hdr[i] = '0;
  endtask

  function automatic kind_t header_kind();
    if (fmt_en[EN_JPEG] && hdr[0] == BYTE_FF && hdr[1] == BYTE_D8 && hdr[2] == BYTE_FF)
      return KIND_JPEG;
    if (fmt_en[EN_BMP] && hdr[0] == BYTE_42 && hdr[1] == BYTE_4D)
      return KIND_BMP;
    if (fmt_en[EN_PNG] && hdr[0] == BYTE_89 && hdr[1] == BYTE_50 && hdr[2] == BYTE_4E &&
        hdr[3] == BYTE_47 && hdr[4] == BYTE_0D && hdr[5] == BYTE_0A &&
        hdr[6] == BYTE_1A && hdr[7] == BYTE_0A)
      return KIND_PNG;
    return KIND_UNKNOWN;
  endfunction

  task automatic sniff_byte(input logic [7:0] b, input logic first, input logic last);
    int    pos;
    logic  complete;
    dims_t r;
    complete = 1'b0;
    if (first) clear_file();
    if (done_q) return;
    pos = int'(pos_q);
    if (pos < HEADER_BYTES) hdr[pos] = b;

    // FF C0 search runs over the header and, for JPEG, the rest of the file
    if (pos < HEADER_BYTES || kind_q == KIND_JPEG) begin
      if (moff == 0) begin
        if (prev_ff && b == BYTE_C0) moff = 4'd1;
        prev_ff = (b == BYTE_FF);
      end else begin
        if (moff < MOFF_MAX) moff = moff + 4'd1;
        if (moff == 4'd5 || moff == 4'd6) hacc = {16'h0, hacc[7:0], b};
        else if (moff == 4'd7 || moff == 4'd8) wacc = {16'h0, wacc[7:0], b};
        if (moff == 4'd8 && kind_q == KIND_JPEG) complete = 1'b1;
      end
    end

    if (pos == HEADER_BYTES - 1) begin
      kind_q = header_kind();
      if (kind_q != KIND_JPEG) begin
        wacc = '0;
        hacc = '0;
      end
    end

    case (kind_q)
      KIND_BMP: begin
        if (pos >= 18 && pos <= 21) wacc = wacc | (32'(b) << (8 * (pos - 18)));
        else if (pos >= 22 && pos <= 25) hacc = hacc | (32'(b) << (8 * (pos - 22)));
        if (pos == 25) complete = 1'b1;
      end
      KIND_PNG: begin
        if (pos >= 16 && pos <= 19) wacc = {wacc[23:0], b};
        else if (pos >= 20 && pos <= 23) hacc = {hacc[23:0], b};
        if (pos == 23) complete = 1'b1;
      end
      default: ;
    endcase

    if (pos_q < POS_MAX) pos_q = pos_q + 5'd1;

    if (complete || last) begin
      r.found  = complete && kind_q != KIND_UNKNOWN && wacc != 0 && hacc != 0;
      r.kind   = kind_q;
      r.width  = r.found ? wacc : '0;
      r.height = r.found ? hacc : '0;
      expected_dims.push_back(r);
      done_q = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    dims_t got;
    dims_t want;
    if (!rst_n) begin
      clear_file();
      fmt_en = 3'd7;
      expected_dims.delete();
      errors = 0;
    end else begin
      // a result beat always belongs to an earlier byte, so check it first
      if (out_tvalid && out_tready) begin
        got.kind   = kind_t'(out_tuser[1:0]);
        got.found  = out_tuser[2];
        got.width  = out_tdata[31:0];
        got.height = out_tdata[63:32];
        if (expected_dims.size() == 0) begin
          $display("%0t: unexpected result: kind %0d width %0d height %0d found %0d",
                   $time, got.kind, got.width, got.height, got.found);
          errors++;
        end else begin
          want = expected_dims.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch: expected kind %0d width %0d height %0d found %0d",
                     $time, want.kind, want.width, want.height, want.found);
            $display("%0t:                  actual kind %0d width %0d height %0d found %0d",
                     $time, got.kind, got.width, got.height, got.found);
            errors++;
          end
        end
      end
      if (cfg_tvalid && cfg_tready) fmt_en = cfg_tdata[2:0];
      if (in_tvalid && in_tready) sniff_byte(in_tdata, in_tuser, in_tlast);
    end
    pending = expected_dims.size();
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the image header dimension parser testbench: clock, reset, file stimulus,
// receiver stalls and verdict. Depends on ihdp_pkg and dimension_checker.
module tb;
  import ihdp_pkg::*;

  localparam int QUIET_LIMIT = 3000;  // cycles with no beat anywhere
  localparam int SEG_BYTES   = 68;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_tvalid;
  logic        cfg_tready;
  logic [7:0]  cfg_tdata;

  int          errors;
  int          pending;
  int          src_idle_pct;
  int          sink_idle_pct;
  logic        hold_req;
  bit          hold_taken = 1'b0;
  int          hold_left = 0;
  int          quiet = 0;
  logic [7:0]  file_bytes[$];
  logic [2:0]  fmt_plan[9];

  always #1 clk = ~clk;

  image_header_dimension_parser_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_tvalid(cfg_tvalid), .cfg_tready(cfg_tready), .cfg_tdata(cfg_tdata)
  );

  dimension_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_tvalid(cfg_tvalid), .cfg_tready(cfg_tready), .cfg_tdata(cfg_tdata),
    .errors(errors), .pending(pending)
  );

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_tvalid && cfg_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic first, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_file(input bit with_first, input int last_at);
    for (int i = 0; i < file_bytes.size(); i++)
      send_beat(file_bytes[i], with_first && i == 0, i == last_at);
  endtask

  // wait until every result is in and the pipeline has drained
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_fmt(input logic [2:0] v);
    cfg_tdata  <= {5'b0, v};
    cfg_tvalid <= 1'b1;
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    @(negedge clk);
    cfg_tvalid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_dim();
    case ($urandom_range(9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2, 3, 4: return 32'($urandom_range(1, 4096));
      default: return $urandom;
    endcase
  endfunction

  // mpos: index of the FF of the FF C0 marker, negative for none
  task automatic build_file(input kind_t shape, input logic [31:0] w,
                            input logic [31:0] h, input int mpos);
    int n;
    file_bytes.delete();
    case (shape)
      KIND_JPEG: begin
        file_bytes = '{BYTE_FF, BYTE_D8, BYTE_FF};
        if (mpos < 0) begin
          repeat (20) file_bytes.push_back(8'($urandom_range(254)));
        end else begin
          while (file_bytes.size() < mpos) file_bytes.push_back(8'($urandom_range(254)));
          if (mpos > 2) file_bytes.push_back(BYTE_FF);
          file_bytes.push_back(BYTE_C0);
          repeat (3) file_bytes.push_back(8'($urandom));
          file_bytes.push_back(h[15:8]);
          file_bytes.push_back(h[7:0]);
          file_bytes.push_back(w[15:8]);
          file_bytes.push_back(w[7:0]);
        end
      end
      KIND_BMP: begin
        file_bytes = '{BYTE_42, BYTE_4D};
        repeat (16) file_bytes.push_back(8'($urandom));
        for (int i = 0; i < 4; i++) file_bytes.push_back(w[8*i +: 8]);
        for (int i = 0; i < 4; i++) file_bytes.push_back(h[8*i +: 8]);
      end
      KIND_PNG: begin
        file_bytes = '{BYTE_89, BYTE_50, BYTE_4E, BYTE_47, BYTE_0D, BYTE_0A, BYTE_1A, BYTE_0A};
        repeat (8) file_bytes.push_back(8'($urandom));
        for (int i = 3; i >= 0; i--) file_bytes.push_back(w[8*i +: 8]);
        for (int i = 3; i >= 0; i--) file_bytes.push_back(h[8*i +: 8]);
      end
      default: begin
        n = $urandom_range(1, 30);
        repeat (n) file_bytes.push_back(8'($urandom));
      end
    endcase
    // a few trailing bytes, ignored once the size is complete
    n = $urandom_range(0, 3);
    repeat (n) file_bytes.push_back(8'($urandom));
  endtask

  task automatic random_file(output int nbytes);
    kind_t shape;
    int    mpos;
    int    r;
    int    cut;
    int    idx;
    shape = kind_t'($urandom_range(3));
    mpos  = ($urandom_range(19) == 0) ? -1 :
            ($urandom_range(7) == 0) ? $urandom_range(13, 30) : $urandom_range(2, 12);
    build_file(shape, rand_dim(), rand_dim(), mpos);
    r = $urandom_range(99);
    if (r < 70) begin
      send_file(1'b1, file_bytes.size() - 1);
    end else if (r < 78) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      send_file(1'b1, file_bytes.size() - 1);
    end else if (r < 85) begin
      // near miss on the signature
      idx = $urandom_range(0, (file_bytes.size() < 8) ? file_bytes.size() - 1 : 7);
      file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
      send_file(1'b1, file_bytes.size() - 1);
    end else if (r < 91) begin
      send_file(1'b1, $urandom_range(0, file_bytes.size() - 1));
    end else if (r < 96) begin
      send_file(1'b1, -1);
    end else begin
      send_file(1'b0, file_bytes.size() - 1);
    end
    nbytes = file_bytes.size();
  endtask

  task automatic run_random(input int budget);
    int sent;
    int n;
    sent = 0;
    while (sent < budget) begin
      random_file(n);
      sent += n;
    end
  endtask

  initial begin
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = 1'b0;
    in_tlast      = 1'b0;
    cfg_tvalid    = 1'b0;
    cfg_tdata     = '0;
    hold_req      = 1'b0;
    rst_n         = 1'b0;
    src_idle_pct  = 26;
    sink_idle_pct = 75;
    fmt_plan      = '{3'd7, 3'd0, 3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'($urandom)};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed files at the reset setting
    build_file(KIND_BMP, 32'd640, 32'd480, 0);
    send_file(1'b0, file_bytes.size() - 1);          // no start flag after reset
    build_file(KIND_JPEG, 32'hFFFF, 32'h0001, 3);    // FF run before C0
    send_file(1'b1, file_bytes.size() - 1);
    build_file(KIND_JPEG, 32'h1234, 32'hABCD, 2);    // marker right after D8
    send_file(1'b1, file_bytes.size() - 1);
    build_file(KIND_PNG, 32'hFFFF_FFFF, 32'h1, 0);
    send_file(1'b1, file_bytes.size() - 1);
    build_file(KIND_PNG, 32'd100, 32'd100, 0);       // short file
    send_file(1'b1, 4);
    build_file(KIND_JPEG, 32'd8, 32'd8, -1);         // no marker
    send_file(1'b1, file_bytes.size() - 1);
    build_file(KIND_BMP, 32'h0, 32'd77, 0);          // zero width
    send_file(1'b1, file_bytes.size() - 1);
    build_file(KIND_PNG, 32'd33, 32'd44, 0);         // truncated dimensions
    send_file(1'b1, 19);
    build_file(KIND_UNKNOWN, 32'd1, 32'd1, 0);
    send_file(1'b1, file_bytes.size() - 1);
    build_file(KIND_JPEG, 32'd320, 32'd200, 30);     // marker at the position limit
    send_file(1'b1, file_bytes.size() - 1);

    for (int mode = 0; mode < 3; mode++) begin
      src_idle_pct  = (mode == 0) ? 26 : (mode == 1) ? 75 : 0;
      sink_idle_pct = (mode == 0) ? 75 : (mode == 1) ? 26 : 0;
      for (int seg = 0; seg < 3; seg++) begin
        settle();
        write_fmt(fmt_plan[mode * 3 + seg]);
        if (mode == 2 && seg == 0) hold_req <= 1'b1;
        run_random(SEG_BYTES);
      end
    end

    settle();
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
